[rtl/fxp_pkg.sv]
// shared types, constants and helper functions of the flat xml field parser
package fxp_pkg;

	localparam int MAX_FIELDS_DEF     = 64;
	localparam int MAX_NAME_LEN_DEF   = 32;
	localparam int ROOT_NAME_SIZE_DEF = 32;
	localparam int LA_DEPTH           = 12;
	localparam int MAXRES             = 16;
	localparam int QDEPTH             = 4;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] BOM_0    = 8'hEF;
	localparam logic [7:0] BOM_1    = 8'hBB;
	localparam logic [7:0] BOM_2    = 8'hBF;

	typedef enum logic [2:0] {
		EV_ROOT = 3'd0,
		EV_NAME = 3'd1,
		EV_VAL  = 3'd2,
		EV_FEND = 3'd3,
		EV_OK   = 3'd4,
		EV_ERR  = 3'd5
	} ev_kind_t;

	typedef struct packed {
		logic       space;
		logic       nstart;
		logic       nchar;
		logic       digit;
		logic       hex;
		logic [3:0] nib;
	} chr_class_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		chr_class_t cls;
	} fxp_item_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] data;
		logic       kept;
		logic [5:0] num;
	} fxp_event_t;

	function automatic chr_class_t classify(input logic [7:0] c);
		chr_class_t r;
		logic alpha;
		logic dig;
		alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
		dig = (c >= 8'h30 && c <= 8'h39);
		r.space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
		r.nstart = alpha || c == 8'h5F || c == 8'h3A;
		r.nchar = alpha || dig || c == 8'h5F || c == 8'h3A || c == CH_DASH || c == 8'h2E;
		r.digit = dig;
		r.hex = dig || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
		r.nib = dig ? c[3:0] : 4'(c[3:0] + 4'd9);
		return r;
	endfunction

	function automatic fxp_event_t mk_ev(input ev_kind_t k, input logic [7:0] d,
			input logic kept, input logic [5:0] num);
		fxp_event_t e;
		e.kind = k;
		e.data = d;
		e.kept = kept;
		e.num = num;
		return e;
	endfunction

	// utf-8 length minus one for a code point
	function automatic logic [1:0] utf8_nm1(input logic [31:0] cp);
		logic [1:0] r;
		if (cp[31:7] == '0) r = 2'd0;
		else if (cp[31:11] == '0) r = 2'd1;
		else if (cp[31:16] == '0) r = 2'd2;
		else r = 2'd3;
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [1:0] nm1,
			input logic [1:0] i);
		logic [7:0] r;
		logic [1:0] sh;
		sh = 2'(nm1 - i);
		if (i == 2'd0) begin
			case (nm1)
				2'd0: r = cp[7:0];
				2'd1: r = 8'hC0 | cp[13:6];
				2'd2: r = 8'hE0 | cp[19:12];
				default: r = 8'hF0 | cp[25:18];
			endcase
		end else begin
			case (sh)
				2'd0: r = {2'b10, cp[5:0]};
				2'd1: r = {2'b10, cp[11:6]};
				default: r = {2'b10, cp[17:12]};
			endcase
		end
		return r;
	endfunction

endpackage

[rtl/flat_xml_field_parser.sv]
// top level of the flat xml field parser: byte queue, parser engine, output port
// path: an accepted byte is written into the queue, then loaded into the parser's byte register;
//   each of its events passes the hold register and then the output register
// flow: each byte is parsed to the end before the next is taken: idle, parse and finish states,
//   a parse step per re-examined byte, value steps per replayed byte and literal replay, a utf
//   step per utf-8 byte and a flush step for an error at the end of a document; output stalls hold the parser
// reset: arst_n clears the queue, the parser state and the output valid flag at once;
//   no clearing pass is needed
module flat_xml_field_parser #(
	parameter int MAX_FIELDS     = fxp_pkg::MAX_FIELDS_DEF,
	parameter int MAX_NAME_LEN   = fxp_pkg::MAX_NAME_LEN_DEF,
	parameter int ROOT_NAME_SIZE = fxp_pkg::ROOT_NAME_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_doc
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] field_kept, [14:9] field_number, [15] zero
	output logic [2:0]  m_tuser,   // [2:0] event_kind
	output logic        m_tlast    // run_last
);
	import fxp_pkg::*;

	logic       item_valid;
	logic       item_ready;
	fxp_item_t  item;
	fxp_event_t ev;

	// front end: classify each byte and hold up to QDEPTH of them in a queue
	fxp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// back end: tag parsing, entity decoding and event output register
	fxp_back #(
		.MAX_FIELDS     (MAX_FIELDS),
		.MAX_NAME_LEN   (MAX_NAME_LEN),
		.ROOT_NAME_SIZE (ROOT_NAME_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.ev         (ev),
		.m_tlast    (m_tlast)
	);

	// pack the event fields onto the stream
	assign m_tdata = {1'b0, ev.num, ev.kept, ev.data};
	assign m_tuser = ev.kind;

	// only defined event kinds leave the block
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= 3'(EV_ERR)))
		else $error("undefined event kind");

	// ok and error end the document, so they close the run of their byte
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == 3'(EV_OK) || m_tuser == 3'(EV_ERR))) |-> m_tlast)
		else $error("document result not last of its byte");

	// kept flag is only raised on field end
	a_kept_fend: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[8]) |-> (m_tuser == 3'(EV_FEND)))
		else $error("kept flag outside field end");

	// marker events carry no byte
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser >= 3'(EV_FEND)) |-> (m_tdata[7:0] == 8'd0))
		else $error("marker event with data byte");

endmodule

[rtl/fxp_front.sv]
// front end: classifies incoming bytes and queues them for the parser
module fxp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte
	input  logic               s_tlast,   // end_of_doc
	output logic               item_valid,
	input  logic               item_ready,
	output fxp_pkg::fxp_item_t item
);
	import fxp_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	fxp_item_t       q_q [QDEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW:0]     cnt_q;
	logic            push;
	logic            pop;

	assign s_tready = cnt_q < (PW+1)'(QDEPTH);
	assign item_valid = cnt_q != '0;
	assign item = q_q[rd_q];
	assign push = s_tvalid && s_tready;
	assign pop = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= '{data: s_tdata, last: s_tlast, cls: classify(s_tdata)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= PW'(wr_q + 1'b1);
			if (pop) rd_q <= PW'(rd_q + 1'b1);
			case ({push, pop})
				2'b10: cnt_q <= (PW+1)'(cnt_q + 1'b1);
				2'b01: cnt_q <= (PW+1)'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/fxp_back.sv]
// back end: tag state machine, entity decoder with replay buffer, event output
module fxp_back #(
	parameter int MAX_FIELDS     = fxp_pkg::MAX_FIELDS_DEF,
	parameter int MAX_NAME_LEN   = fxp_pkg::MAX_NAME_LEN_DEF,
	parameter int ROOT_NAME_SIZE = fxp_pkg::ROOT_NAME_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  fxp_pkg::fxp_item_t  item,
	output logic                m_tvalid,
	input  logic                m_tready,
	output fxp_pkg::fxp_event_t ev,
	output logic                m_tlast
);
	import fxp_pkg::*;

	localparam int FW = $clog2(MAX_FIELDS + 1);

	typedef enum logic [2:0] {E_IDLE, E_PARSE, E_VAL, E_UTF, E_FIN, E_FLUSH} eng_t;

	typedef enum logic [4:0] {
		PH_START, PH_JUNK, PH_LT, PH_PI, PH_PI_Q, PH_BANG, PH_BANG_DASH,
		PH_CMT0, PH_CMT1, PH_CMT2, PH_DECL, PH_ROOT_NAME, PH_CHILD_NAME,
		PH_TAIL, PH_TAIL_SLASH, PH_TAIL_QUOTE, PH_VALUE, PH_VALUE_LT,
		PH_CLOSE, PH_ROOT_CLOSE
	} phase_t;

	eng_t          eng_q;
	phase_t        phase_q;
	fxp_item_t     cur_q;
	logic          need_c_q;
	logic          lt_mode_q;
	logic [7:0]    la_q [LA_DEPTH];
	logic [3:0]    cnt_q;
	logic          src_pq_q;
	logic [3:0]    base_q;
	logic [31:0]   acc_q;
	logic          num_ok_q;
	logic          hex_q;
	logic [7:0]    pq_q [LA_DEPTH];
	logic [3:0]    len_q;
	logic [3:0]    rd_q;
	logic [1:0]    utf_n_q;
	logic [1:0]    utf_i_q;
	logic [FW-1:0] fields_q;
	logic [7:0]    nlen_q;
	logic          quote_single_q;
	logic [1:0]    bom_q;
	logic          fin_q;
	logic          in_root_q;
	logic          hold_v_q;
	fxp_event_t    hold_q;
	logic [4:0]    res_cnt_q;
	logic          m_tvalid_q;
	fxp_event_t    out_q;
	logic          out_last_q;

	logic          adv;
	logic          named_hit;
	logic [7:0]    named_byte;
	logic          num_valid;
	logic          kept;
	logic [5:0]    fnum;

	assign adv = !m_tvalid_q || m_tready;
	assign item_ready = (eng_q == E_IDLE) && adv;
	assign m_tvalid = m_tvalid_q;
	assign ev = out_q;
	assign m_tlast = out_last_q;
	assign fnum = 6'(fields_q);
	assign kept = (fields_q < FW'(MAX_FIELDS)) && (nlen_q < 8'(MAX_NAME_LEN));
	assign num_valid = num_ok_q && cnt_q >= 4'd3 && (!hex_q || cnt_q >= 4'd4);

	// named entities, body in la_q[1..]
	always_comb begin
		named_hit = 1'b0;
		named_byte = CH_AMP;
		if (cnt_q == 4'd4 && la_q[1] == "a" && la_q[2] == "m" && la_q[3] == "p") begin
			named_hit = 1'b1;
			named_byte = CH_AMP;
		end else if (cnt_q == 4'd3 && la_q[1] == "l" && la_q[2] == "t") begin
			named_hit = 1'b1;
			named_byte = CH_LT;
		end else if (cnt_q == 4'd3 && la_q[1] == "g" && la_q[2] == "t") begin
			named_hit = 1'b1;
			named_byte = CH_GT;
		end else if (cnt_q == 4'd5 && la_q[1] == "a" && la_q[2] == "p" && la_q[3] == "o"
				&& la_q[4] == "s") begin
			named_hit = 1'b1;
			named_byte = CH_SQUOT;
		end else if (cnt_q == 4'd5 && la_q[1] == "q" && la_q[2] == "u" && la_q[3] == "o"
				&& la_q[4] == "t") begin
			named_hit = 1'b1;
			named_byte = CH_DQUOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin : seq
		logic       gen;
		fxp_event_t gev;
		logic       vc;
		logic [7:0] vb;
		chr_class_t vk;
		logic       vpq;
		logic       rep;
		logic       rep_with;
		logic       push;
		fxp_event_t pev;
		logic       plast;
		logic [7:0] c;
		chr_class_t k;
		if (!arst_n) begin
			eng_q <= E_IDLE;
			phase_q <= PH_START;
			need_c_q <= 1'b0;
			lt_mode_q <= 1'b0;
			cnt_q <= '0;
			src_pq_q <= 1'b0;
			base_q <= '0;
			acc_q <= '0;
			num_ok_q <= 1'b0;
			hex_q <= 1'b0;
			len_q <= '0;
			rd_q <= '0;
			utf_n_q <= '0;
			utf_i_q <= '0;
			fields_q <= '0;
			nlen_q <= '0;
			quote_single_q <= 1'b0;
			bom_q <= '0;
			fin_q <= 1'b0;
			in_root_q <= 1'b0;
			hold_v_q <= 1'b0;
			res_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			gen = 1'b0;
			gev = '0;
			vc = 1'b0;
			vb = '0;
			vk = '0;
			vpq = 1'b0;
			rep = 1'b0;
			rep_with = 1'b0;
			push = 1'b0;
			pev = hold_q;
			plast = 1'b0;
			c = cur_q.data;
			k = cur_q.cls;
			if (m_tready) m_tvalid_q <= 1'b0;
			if (adv) begin
				case (eng_q)
					E_IDLE: begin
						if (item_valid) begin
							cur_q <= item;
							res_cnt_q <= '0;
							eng_q <= fin_q ? E_FIN : E_PARSE;
						end
					end
					E_PARSE: begin
						eng_q <= E_FIN;
						case (phase_q)
							PH_START: begin
								if (bom_q == 2'd0) begin
									if (c == BOM_0) bom_q <= 2'd1;
									else begin
										phase_q <= PH_JUNK;
										eng_q <= E_PARSE;
									end
								end else if (bom_q == 2'd1) begin
									if (c == BOM_1) bom_q <= 2'd2;
									else begin
										gen = 1'b1;
										gev = mk_ev(EV_ERR, '0, 1'b0, '0);
										fin_q <= 1'b1;
									end
								end else begin
									if (c == BOM_2) begin
										bom_q <= 2'd3;
										phase_q <= PH_JUNK;
									end else begin
										gen = 1'b1;
										gev = mk_ev(EV_ERR, '0, 1'b0, '0);
										fin_q <= 1'b1;
									end
								end
							end
							PH_JUNK: begin
								if (c == CH_LT) phase_q <= PH_LT;
								else if (!k.space) begin
									gen = 1'b1;
									gev = mk_ev(EV_ERR, '0, 1'b0, '0);
									fin_q <= 1'b1;
								end
							end
							PH_LT: begin
								if (c == CH_QMARK) phase_q <= PH_PI;
								else if (c == CH_BANG) phase_q <= PH_BANG;
								else if (in_root_q && c == CH_SLASH) phase_q <= PH_ROOT_CLOSE;
								else if (k.nstart) begin
									nlen_q <= 8'd1;
									gen = 1'b1;
									if (in_root_q) begin
										gev = mk_ev(EV_NAME, c, 1'b0, fnum);
										phase_q <= PH_CHILD_NAME;
									end else begin
										gev = mk_ev(EV_ROOT, c, 1'b0, '0);
										phase_q <= PH_ROOT_NAME;
									end
								end else begin
									gen = 1'b1;
									gev = mk_ev(EV_ERR, '0, 1'b0, '0);
									fin_q <= 1'b1;
								end
							end
							PH_PI: if (c == CH_QMARK) phase_q <= PH_PI_Q;
							PH_PI_Q: begin
								if (c == CH_GT) phase_q <= PH_JUNK;
								else if (c != CH_QMARK) phase_q <= PH_PI;
							end
							PH_BANG: begin
								if (c == CH_DASH) phase_q <= PH_BANG_DASH;
								else if (c == CH_GT) phase_q <= PH_JUNK;
								else phase_q <= PH_DECL;
							end
							PH_BANG_DASH: begin
								if (c == CH_DASH) phase_q <= PH_CMT0;
								else if (c == CH_GT) phase_q <= PH_JUNK;
								else phase_q <= PH_DECL;
							end
							PH_CMT0: if (c == CH_DASH) phase_q <= PH_CMT1;
							PH_CMT1: phase_q <= (c == CH_DASH) ? PH_CMT2 : PH_CMT0;
							PH_CMT2: begin
								if (c == CH_GT) phase_q <= PH_JUNK;
								else if (c != CH_DASH) phase_q <= PH_CMT0;
							end
							PH_DECL: if (c == CH_GT) phase_q <= PH_JUNK;
							PH_ROOT_NAME: begin
								if (k.nchar) begin
									gen = 1'b1;
									if ({1'b0, nlen_q} + 9'd1 >= 9'(ROOT_NAME_SIZE)) begin
										gev = mk_ev(EV_ERR, '0, 1'b0, '0);
										fin_q <= 1'b1;
									end else begin
										nlen_q <= 8'(nlen_q + 1'b1);
										gev = mk_ev(EV_ROOT, c, 1'b0, '0);
									end
								end else begin
									phase_q <= PH_TAIL;
									eng_q <= E_PARSE;
								end
							end
							PH_CHILD_NAME: begin
								if (k.nchar) begin
									if (nlen_q != 8'hFF) nlen_q <= 8'(nlen_q + 1'b1);
									gen = 1'b1;
									gev = mk_ev(EV_NAME, c, 1'b0, fnum);
								end else begin
									phase_q <= PH_TAIL;
									eng_q <= E_PARSE;
								end
							end
							PH_TAIL: begin
								if (c == CH_GT) begin
									if (!in_root_q) begin
										in_root_q <= 1'b1;
										phase_q <= PH_JUNK;
									end else phase_q <= PH_VALUE;
								end else if (c == CH_SLASH) phase_q <= PH_TAIL_SLASH;
								else if (c == CH_DQUOT || c == CH_SQUOT) begin
									quote_single_q <= (c == CH_SQUOT);
									phase_q <= PH_TAIL_QUOTE;
								end
							end
							PH_TAIL_SLASH: begin
								if (c == CH_GT) begin
									gen = 1'b1;
									if (!in_root_q) begin
										gev = mk_ev(EV_OK, '0, 1'b0, '0);
										fin_q <= 1'b1;
									end else begin
										// self-closing child ends the field at once
										gev = mk_ev(EV_FEND, '0, kept, fnum);
										if (kept) fields_q <= FW'(fields_q + 1'b1);
										phase_q <= PH_JUNK;
									end
								end else begin
									phase_q <= PH_TAIL;
									eng_q <= E_PARSE;
								end
							end
							PH_TAIL_QUOTE: begin
								if (c == (quote_single_q ? CH_SQUOT : CH_DQUOT)) phase_q <= PH_TAIL;
							end
							PH_VALUE: begin
								eng_q <= E_VAL;
								lt_mode_q <= (c == CH_LT);
								need_c_q <= (c != CH_LT);
							end
							PH_VALUE_LT: begin
								if (c == CH_SLASH) phase_q <= PH_CLOSE;
								else begin
									gen = 1'b1;
									gev = mk_ev(EV_ERR, '0, 1'b0, '0);
									fin_q <= 1'b1;
								end
							end
							PH_CLOSE: begin
								if (c == CH_GT) begin
									gen = 1'b1;
									gev = mk_ev(EV_FEND, '0, kept, fnum);
									if (kept) fields_q <= FW'(fields_q + 1'b1);
									phase_q <= PH_JUNK;
								end
							end
							PH_ROOT_CLOSE: begin
								if (c == CH_GT) begin
									gen = 1'b1;
									gev = mk_ev(EV_OK, '0, 1'b0, '0);
									fin_q <= 1'b1;
								end
							end
							default: begin
								gen = 1'b1;
								gev = mk_ev(EV_ERR, '0, 1'b0, '0);
								fin_q <= 1'b1;
							end
						endcase
					end
					E_VAL: begin
						if (need_c_q) begin
							vc = 1'b1;
							vb = c;
							vk = k;
							need_c_q <= 1'b0;
						end else if (rd_q < len_q) begin
							vc = 1'b1;
							vb = pq_q[rd_q];
							vk = classify(vb);
							vpq = 1'b1;
							rd_q <= 4'(rd_q + 1'b1);
						end else if (lt_mode_q && cnt_q != '0) begin
							rep = 1'b1;
						end else begin
							if (lt_mode_q) phase_q <= PH_VALUE_LT;
							eng_q <= E_FIN;
						end
						if (vc) begin
							if (cnt_q == '0) begin
								if (vb == CH_AMP) begin
									la_q[0] <= vb;
									cnt_q <= 4'd1;
									src_pq_q <= vpq;
									base_q <= rd_q;
								end else begin
									gen = 1'b1;
									gev = mk_ev(EV_VAL, vb, 1'b0, fnum);
								end
							end else if (vb == CH_SEMI) begin
								if (named_hit) begin
									gen = 1'b1;
									gev = mk_ev(EV_VAL, named_byte, 1'b0, fnum);
									cnt_q <= '0;
								end else if (num_valid) begin
									cnt_q <= '0;
									utf_n_q <= utf8_nm1(acc_q);
									utf_i_q <= '0;
									eng_q <= E_UTF;
								end else begin
									rep = 1'b1;
									rep_with = 1'b1;
								end
							end else if (cnt_q < 4'(LA_DEPTH)) begin
								la_q[cnt_q] <= vb;
								cnt_q <= 4'(cnt_q + 1'b1);
								if (!vpq) src_pq_q <= 1'b0;
								// running numeric reference decode
								if (cnt_q == 4'd1) begin
									num_ok_q <= (vb == CH_HASH);
									hex_q <= 1'b0;
									acc_q <= '0;
								end else if (cnt_q == 4'd2) begin
									if (vb == "x" || vb == "X") hex_q <= 1'b1;
									else if (vk.digit) acc_q <= {28'd0, vk.nib};
									else num_ok_q <= 1'b0;
								end else if (hex_q) begin
									if (vk.hex) acc_q <= {acc_q[27:0], vk.nib};
									else num_ok_q <= 1'b0;
								end else begin
									if (vk.digit) acc_q <= (acc_q << 3) + (acc_q << 1) + {28'd0, vk.nib};
									else num_ok_q <= 1'b0;
								end
							end else begin
								rep = 1'b1;
								rep_with = 1'b1;
							end
						end
						if (rep) begin
							// literal amp, then the entity body goes back through the decoder
							gen = 1'b1;
							gev = mk_ev(EV_VAL, CH_AMP, 1'b0, fnum);
							cnt_q <= '0;
							if (src_pq_q && (vpq || !rep_with)) begin
								rd_q <= 4'(base_q + 1'b1);
							end else begin
								for (int i = 0; i < LA_DEPTH - 1; i++) pq_q[i] <= la_q[i+1];
								if (rep_with) pq_q[4'(cnt_q - 1'b1)] <= vb;
								len_q <= 4'(cnt_q - 4'd1 + {3'd0, rep_with});
								rd_q <= '0;
							end
						end
					end
					E_UTF: begin
						gen = 1'b1;
						gev = mk_ev(EV_VAL, utf8_byte(acc_q, utf_n_q, utf_i_q), 1'b0, fnum);
						if (utf_i_q == utf_n_q) eng_q <= E_VAL;
						else utf_i_q <= 2'(utf_i_q + 1'b1);
					end
					E_FIN: begin
						if (cur_q.last && !fin_q && res_cnt_q < 5'(MAXRES)) begin
							gen = 1'b1;
							gev = mk_ev(EV_ERR, '0, 1'b0, '0);
							eng_q <= E_FLUSH;
						end else begin
							push = hold_v_q;
							plast = 1'b1;
							hold_v_q <= 1'b0;
							eng_q <= E_IDLE;
						end
						if (cur_q.last) begin
							phase_q <= PH_START;
							cnt_q <= '0;
							acc_q <= '0;
							fields_q <= '0;
							nlen_q <= '0;
							quote_single_q <= 1'b0;
							bom_q <= '0;
							fin_q <= 1'b0;
							in_root_q <= 1'b0;
							len_q <= '0;
							rd_q <= '0;
						end
					end
					E_FLUSH: begin
						push = hold_v_q;
						plast = 1'b1;
						hold_v_q <= 1'b0;
						eng_q <= E_IDLE;
					end
					default: eng_q <= E_IDLE;
				endcase
				// one event is held back so the last one of a byte can be marked
				if (gen && res_cnt_q < 5'(MAXRES)) begin
					if (hold_v_q) begin
						push = 1'b1;
						plast = 1'b0;
					end
					hold_q <= gev;
					hold_v_q <= 1'b1;
					res_cnt_q <= 5'(res_cnt_q + 1'b1);
				end
				if (push) begin
					m_tvalid_q <= 1'b1;
					out_q <= pev;
					out_last_q <= plast;
				end
			end
		end
	end

endmodule

[sim/fxp_checker.sv]
// event predictor and scoreboard for the flat xml field parser
`timescale 1ns / 100ps
module fxp_checker #(
	parameter int MAX_FIELDS     = fxp_pkg::MAX_FIELDS_DEF,
	parameter int MAX_NAME_LEN   = fxp_pkg::MAX_NAME_LEN_DEF,
	parameter int ROOT_NAME_SIZE = fxp_pkg::ROOT_NAME_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	output int          mismatches,
	output int          events_waiting,
	output int          events_checked
);
	import fxp_pkg::*;

	typedef enum int {
		P_START, P_JUNK, P_LT, P_PI, P_PI_Q, P_BANG, P_BANG_DASH, P_CMT0, P_CMT1, P_CMT2,
		P_DECL, P_ROOT_NAME, P_CHILD_NAME, P_TAIL, P_TAIL_SLASH, P_TAIL_QUOTE, P_VALUE,
		P_VALUE_LT, P_CLOSE, P_ROOT_CLOSE
	} phase_t;

	typedef struct {
		ev_kind_t   kind;
		logic [7:0] b;
		logic       kept;
		logic [5:0] num;
		logic       last;
	} xml_event_t;

	localparam int REPLAY_CAP = 32;

	// parser state copy
	phase_t      phase;
	logic [7:0]  ent_buf [LA_DEPTH];
	int          ent_len;
	logic [31:0] code_point;
	int          kept_fields;
	int          tag_len;
	logic        single_quote;
	int          bom_state;
	logic        doc_done;
	logic        inside_root;
	logic [7:0]  replay_q [$];

	xml_event_t  step_events [$];
	xml_event_t  expected_events [$];

	function automatic logic is_space(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction
	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction
	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic logic is_name_start(logic [7:0] c);
		return is_alpha(c) || c == "_" || c == ":";
	endfunction
	function automatic logic is_name_byte(logic [7:0] c);
		return is_name_start(c) || is_digit(c) || c == CH_DASH || c == ".";
	endfunction

	task automatic add_event(ev_kind_t k, logic [7:0] b, logic kept, int num);
		xml_event_t e;
		if (step_events.size() >= MAXRES)
			return;
		e.kind = k;
		e.b = b;
		e.kept = kept;
		e.num = 6'(num);
		e.last = 1'b0;
		step_events.push_back(e);
	endtask

	task automatic end_doc(logic ok);
		add_event(ok ? EV_OK : EV_ERR, 8'h00, 1'b0, 0);
		doc_done = 1'b1;
	endtask

	task automatic value_out(logic [7:0] b);
		add_event(EV_VAL, b, 1'b0, kept_fields);
	endtask

	task automatic utf8_out(logic [31:0] cp);
		if (cp <= 32'h7F) begin
			value_out(cp[7:0]);
		end else if (cp <= 32'h7FF) begin
			value_out(8'(32'hC0 | (cp >> 6)));
			value_out(8'(32'h80 | (cp & 32'h3F)));
		end else if (cp <= 32'hFFFF) begin
			value_out(8'(32'hE0 | (cp >> 12)));
			value_out(8'(32'h80 | ((cp >> 6) & 32'h3F)));
			value_out(8'(32'h80 | (cp & 32'h3F)));
		end else begin
			value_out(8'(32'hF0 | (cp >> 18)));
			value_out(8'(32'h80 | ((cp >> 12) & 32'h3F)));
			value_out(8'(32'h80 | ((cp >> 6) & 32'h3F)));
			value_out(8'(32'h80 | (cp & 32'h3F)));
		end
	endtask

	// entity body is ent_buf[1 .. ent_len-1]
	function automatic logic body_matches(string s);
		if (ent_len - 1 != s.len())
			return 1'b0;
		for (int i = 0; i < s.len(); i++)
			if (ent_buf[i + 1] != s[i])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic decode_entity(output logic ok);
		int n;
		logic [7:0] ch;
		logic [3:0] nib;
		n = ent_len - 1;
		ok = 1'b1;
		if (body_matches("amp")) begin value_out(CH_AMP); return; end
		if (body_matches("lt")) begin value_out(CH_LT); return; end
		if (body_matches("gt")) begin value_out(CH_GT); return; end
		if (body_matches("apos")) begin value_out(CH_SQUOT); return; end
		if (body_matches("quot")) begin value_out(CH_DQUOT); return; end
		ok = 1'b0;
		if (n < 2 || ent_buf[1] != CH_HASH)
			return;
		code_point = '0;
		if (ent_buf[2] == "x" || ent_buf[2] == "X") begin
			if (n < 3)
				return;
			for (int k = 3; k <= n; k++) begin
				ch = ent_buf[k];
				if (is_digit(ch)) nib = 4'(ch - "0");
				else if (ch >= "a" && ch <= "f") nib = 4'(ch - "a" + 10);
				else if (ch >= "A" && ch <= "F") nib = 4'(ch - "A" + 10);
				else return;
				code_point = (code_point << 4) | 32'(nib);
			end
		end else begin
			for (int k = 2; k <= n; k++) begin
				if (!is_digit(ent_buf[k]))
					return;
				code_point = code_point * 32'd10 + 32'(ent_buf[k] - "0");
			end
		end
		utf8_out(code_point);
		ok = 1'b1;
	endtask

	// literal ampersand, then the buffered body (and maybe one byte) is parsed again
	task automatic replay_entity(logic with_byte, logic [7:0] c);
		logic [7:0] body [$];
		for (int k = 1; k < ent_len && k < LA_DEPTH; k++)
			body.push_back(ent_buf[k]);
		if (with_byte)
			body.push_back(c);
		ent_len = 0;
		value_out(CH_AMP);
		while (replay_q.size() + body.size() > REPLAY_CAP)
			void'(replay_q.pop_back());
		for (int k = body.size() - 1; k >= 0; k--)
			replay_q.push_front(body[k]);
	endtask

	task automatic value_byte(logic [7:0] c);
		logic ok;
		if (ent_len == 0) begin
			if (c == CH_AMP) begin
				ent_buf[0] = c;
				ent_len = 1;
			end else begin
				value_out(c);
			end
		end else if (c == CH_SEMI) begin
			decode_entity(ok);
			if (ok)
				ent_len = 0;
			else
				replay_entity(1'b1, c);
		end else if (ent_len < LA_DEPTH) begin
			ent_buf[ent_len] = c;
			ent_len++;
		end else begin
			replay_entity(1'b1, c);
		end
	endtask

	task automatic drain_replay();
		logic [7:0] b;
		while (replay_q.size() > 0) begin
			b = replay_q.pop_front();
			value_byte(b);
		end
	endtask

	task automatic close_field();
		logic kept;
		kept = kept_fields < MAX_FIELDS && tag_len < MAX_NAME_LEN;
		add_event(EV_FEND, 8'h00, kept, kept_fields);
		if (kept)
			kept_fields++;
	endtask

	task automatic tag_closed(logic self_close);
		if (!inside_root) begin
			if (self_close) begin
				end_doc(1'b1);
			end else begin
				inside_root = 1'b1;
				phase = P_JUNK;
			end
		end else if (self_close) begin
			close_field();
			phase = P_JUNK;
		end else begin
			phase = P_VALUE;
		end
	endtask

	task automatic parse_byte(logic [7:0] c);
		logic again;
		again = 1'b1;
		while (again && !doc_done) begin
			again = 1'b0;
			case (phase)
				P_START: begin
					if (bom_state == 0) begin
						if (c == BOM_0) bom_state = 1;
						else begin phase = P_JUNK; again = 1'b1; end
					end else if (bom_state == 1) begin
						if (c == BOM_1) bom_state = 2; else end_doc(1'b0);
					end else begin
						if (c == BOM_2) begin bom_state = 3; phase = P_JUNK; end
						else end_doc(1'b0);
					end
				end
				P_JUNK: begin
					if (c == CH_LT) phase = P_LT;
					else if (!is_space(c)) end_doc(1'b0);
				end
				P_LT: begin
					if (c == CH_QMARK) phase = P_PI;
					else if (c == CH_BANG) phase = P_BANG;
					else if (inside_root && c == CH_SLASH) phase = P_ROOT_CLOSE;
					else if (is_name_start(c)) begin
						tag_len = 1;
						if (inside_root) begin
							add_event(EV_NAME, c, 1'b0, kept_fields);
							phase = P_CHILD_NAME;
						end else begin
							add_event(EV_ROOT, c, 1'b0, 0);
							phase = P_ROOT_NAME;
						end
					end else end_doc(1'b0);
				end
				P_PI: if (c == CH_QMARK) phase = P_PI_Q;
				P_PI_Q: begin
					if (c == CH_GT) phase = P_JUNK;
					else if (c != CH_QMARK) phase = P_PI;
				end
				P_BANG: phase = (c == CH_DASH) ? P_BANG_DASH : (c == CH_GT) ? P_JUNK : P_DECL;
				P_BANG_DASH: phase = (c == CH_DASH) ? P_CMT0 : (c == CH_GT) ? P_JUNK : P_DECL;
				P_CMT0: if (c == CH_DASH) phase = P_CMT1;
				P_CMT1: phase = (c == CH_DASH) ? P_CMT2 : P_CMT0;
				P_CMT2: begin
					if (c == CH_GT) phase = P_JUNK;
					else if (c != CH_DASH) phase = P_CMT0;
				end
				P_DECL: if (c == CH_GT) phase = P_JUNK;
				P_ROOT_NAME: begin
					if (is_name_byte(c)) begin
						if (tag_len + 1 >= ROOT_NAME_SIZE) end_doc(1'b0);
						else begin
							tag_len++;
							add_event(EV_ROOT, c, 1'b0, 0);
						end
					end else begin
						phase = P_TAIL;
						again = 1'b1;
					end
				end
				P_CHILD_NAME: begin
					if (is_name_byte(c)) begin
						if (tag_len < 255) tag_len++;
						add_event(EV_NAME, c, 1'b0, kept_fields);
					end else begin
						phase = P_TAIL;
						again = 1'b1;
					end
				end
				P_TAIL: begin
					if (c == CH_GT) tag_closed(1'b0);
					else if (c == CH_SLASH) phase = P_TAIL_SLASH;
					else if (c == CH_DQUOT || c == CH_SQUOT) begin
						single_quote = (c == CH_SQUOT);
						phase = P_TAIL_QUOTE;
					end
				end
				P_TAIL_SLASH: begin
					if (c == CH_GT) tag_closed(1'b1);
					else begin
						phase = P_TAIL;
						again = 1'b1;
					end
				end
				P_TAIL_QUOTE: if (c == (single_quote ? CH_SQUOT : CH_DQUOT)) phase = P_TAIL;
				P_VALUE: begin
					if (c == CH_LT) begin
						// an entity cut short by the tag goes out literally
						while (ent_len != 0) begin
							replay_entity(1'b0, 8'h00);
							drain_replay();
						end
						phase = P_VALUE_LT;
					end else begin
						replay_q.delete();
						replay_q.push_back(c);
						drain_replay();
					end
				end
				P_VALUE_LT: if (c == CH_SLASH) phase = P_CLOSE; else end_doc(1'b0);
				P_CLOSE: begin
					if (c == CH_GT) begin
						close_field();
						phase = P_JUNK;
					end
				end
				P_ROOT_CLOSE: if (c == CH_GT) end_doc(1'b1);
				default: end_doc(1'b0);
			endcase
		end
	endtask

	task automatic clear_doc();
		phase = P_START;
		ent_len = 0;
		code_point = '0;
		kept_fields = 0;
		tag_len = 0;
		single_quote = 1'b0;
		bom_state = 0;
		doc_done = 1'b0;
		inside_root = 1'b0;
		replay_q.delete();
	endtask

	task automatic predict_byte(logic [7:0] c, logic last);
		step_events.delete();
		if (!doc_done)
			parse_byte(c);
		if (last) begin
			if (!doc_done)
				end_doc(1'b0);
			clear_doc();
		end
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1'b1;
		foreach (step_events[i])
			expected_events.push_back(step_events[i]);
	endtask

	initial begin
		foreach (ent_buf[i])
			ent_buf[i] = 8'h00;
		clear_doc();
	end

	always @(posedge clk) begin
		xml_event_t e;
		if (!arst_n) begin
			mismatches <= 0;
			events_checked <= 0;
			events_waiting <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				events_checked <= events_checked + 1;
				if (expected_events.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("%0t: unexpected event kind %0d data %h", $realtime,
							m_tuser, m_tdata);
				end else begin
					e = expected_events.pop_front();
					if (m_tuser != e.kind || m_tdata[7:0] != e.b || m_tdata[8] != e.kept ||
							m_tdata[14:9] != e.num || m_tdata[15] != 1'b0 ||
							m_tlast != e.last) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display({"%0t: event mismatch, expected kind %0d byte %h kept %b",
								" num %0d last %b, got kind %0d byte %h kept %b num %0d",
								" last %b (bit15 %b)"}, $realtime, e.kind, e.b, e.kept,
								e.num, e.last, m_tuser, m_tdata[7:0], m_tdata[8],
								m_tdata[14:9], m_tlast, m_tdata[15]);
					end
				end
			end
			events_waiting <= expected_events.size();
		end
	end

endmodule

[sim/tb_top.sv]
// stimulus, clock, reset and verdict for the flat xml field parser
`timescale 1ns / 100ps
module tb_top;
	import fxp_pkg::*;

	// idling modes, cycled from document to document
	localparam int MODE_NONE   = 0;
	localparam int MODE_SENDER = 1;
	localparam int MODE_RECV   = 2;
	localparam int MODE_BOTH   = 3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int mismatches;
	int events_waiting;
	int events_checked;
	int idle_mode;
	int bytes_sent;
	int docs_sent;

	logic [7:0] doc_q [$];

	flat_xml_field_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	fxp_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatches     (mismatches),
		.events_waiting (events_waiting),
		.events_checked (events_checked)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// receiver back-pressure follows the current idling mode
	always @(posedge clk) begin
		case (idle_mode)
			MODE_RECV: m_tready <= $urandom_range(99) >= 72;
			MODE_BOTH: m_tready <= $urandom_range(99) >= 7;
			default:   m_tready <= 1'b1;
		endcase
	end

	// hard stop in case the block hangs
	initial begin
		#4_000_000;
		$display("timeout with %0d events outstanding", events_waiting);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			doc_q.push_back(s[i]);
	endfunction

	function automatic string rand_name(int len);
		string s;
		string pool;
		pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_:0123456789-.";
		s = "";
		// first char must be a name start
		s = {s, string'(pool[$urandom_range(53)])};
		for (int i = 1; i < len; i++)
			s = {s, string'(pool[$urandom_range(pool.len() - 1)])};
		return s;
	endfunction

	function automatic void add_junk();
		case ($urandom_range(5))
			0: add_text(" \t\n");
			1: add_text("<?xml v='1'?>");
			2: add_text("<!-- c - -x-->");
			3: add_text("<!DOCTYPE r>");
			4: add_text("<!>");
			default: ;
		endcase
	endfunction

	function automatic void add_attrs();
		case ($urandom_range(3))
			0: add_text(" k=\"a>'/\"");
			1: add_text(" k='q\">' z");
			default: ;
		endcase
	endfunction

	function automatic void add_value();
		string ents [16];
		logic [7:0] b;
		ents = '{"&amp;", "&lt;", "&gt;", "&apos;", "&quot;", "&#65;", "&#x20AC;", "&#233;",
			"&#x1F600;", "&#99999999999;", "&#xFFFFFFFFF;", "&bogus;", "&&amp;",
			"&abcdefghijklmnop", "&#;", "&#x;"};
		repeat ($urandom_range(6)) begin
			case ($urandom_range(3))
				0: add_text(ents[$urandom_range(15)]);
				1: begin
					b = 8'($urandom_range(255));
					doc_q.push_back(b == CH_LT ? "v" : b);
				end
				default: add_text(rand_name($urandom_range(1, 3)));
			endcase
		end
		if ($urandom_range(9) == 0)
			add_text("&am");
	endfunction

	function automatic void build_doc(int n_fields, logic long_names);
		string root;
		string nm;
		if ($urandom_range(4) == 0) begin
			doc_q.push_back(BOM_0);
			doc_q.push_back(BOM_1);
			doc_q.push_back(BOM_2);
		end
		add_junk();
		root = rand_name(long_names && $urandom_range(3) == 0 ? 34 : $urandom_range(1, 4));
		add_text({"<", root});
		add_attrs();
		if ($urandom_range(9) == 0) begin
			add_text("/>");
			return;
		end
		add_text(">");
		for (int f = 0; f < n_fields; f++) begin
			add_junk();
			nm = rand_name(long_names && $urandom_range(3) == 0 ? $urandom_range(31, 36)
				: $urandom_range(1, 4));
			add_text({"<", nm});
			add_attrs();
			if ($urandom_range(4) == 0) begin
				add_text("/>");
			end else begin
				add_text(">");
				add_value();
				add_text({"</", nm, ">"});
			end
		end
		add_text({"</", root, ">"});
	endfunction

	// broken documents: a bad byte, an early end, trailing bytes, or a stray '<'
	function automatic void break_doc();
		int pos;
		pos = $urandom_range(doc_q.size() - 1);
		case ($urandom_range(3))
			0: doc_q[pos] = 8'($urandom_range(255));
			1: while (doc_q.size() > pos + 1) void'(doc_q.pop_back());
			2: add_text(" tail<x>");
			default: doc_q.insert(pos, "<");
		endcase
	endfunction

	task automatic send_doc();
		int gap_pct;
		idle_mode = docs_sent % 4;
		gap_pct = idle_mode == MODE_SENDER ? 72 : idle_mode == MODE_BOTH ? 7 : 0;
		foreach (doc_q[i]) begin
			s_tvalid <= 1'b1;
			s_tdata <= doc_q[i];
			s_tlast <= (i == doc_q.size() - 1);
			do @(posedge clk); while (!s_tready);
			bytes_sent++;
			if ($urandom_range(99) < gap_pct) begin
				s_tvalid <= 1'b0;
				while ($urandom_range(99) < gap_pct)
					@(posedge clk);
				@(posedge clk);
			end
		end
		docs_sent++;
		doc_q.delete();
	endtask

	task automatic send_text(string s);
		add_text(s);
		send_doc();
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		idle_mode = MODE_NONE;
		bytes_sent = 0;
		docs_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bom, partial bom, stray text, empty root, nested tag, entities
		doc_q = '{BOM_0, BOM_1, BOM_2};
		send_text("<r/>");
		doc_q = '{BOM_0, 8'hFF};
		send_doc();
		send_text("x");
		send_text("<r><v>&amp;&lt;&#4294967295;&#xE9;&q&lt</v></r> zz");
		send_text("<r><a>1<b");

		// one document past the kept-field limit and with one overlong field name
		add_text("<r>");
		add_text({"<", rand_name(33), "/>"});
		for (int f = 0; f < MAX_FIELDS_DEF + 1; f++)
			add_text("<f/>");
		send_text("</r>");

		// random documents through all idling modes
		while (bytes_sent < 400) begin
			build_doc($urandom_range(0, 5), $urandom_range(1) == 0);
			if ($urandom_range(4) == 0)
				break_doc();
			send_doc();
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		waited = 0;
		while (events_waiting != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);

		$display("sent %0d documents, %0d bytes; %0d events compared", docs_sent,
			bytes_sent, events_checked);
		if (mismatches == 0 && events_waiting == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d events never seen", mismatches, events_waiting);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
